// ===== src/arcc_pkg.sv =====
// ----------------------------------------------------------------------------
// arcc_pkg
// Shared types and constants for the axis range and center calibrator.
// ----------------------------------------------------------------------------
package arcc_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int COUNT_BITS    = 16;
  localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_BITS     = $clog2(SUM_BITS);
  localparam int MODE_BITS     = 2;
  localparam int PHASE_BITS    = 2;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  // item modes
  localparam logic [MODE_BITS-1:0] MODE_SAMPLE   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_EXTREMES = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CENTER   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_INIT_MIN    = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_INIT_CENTER = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_INIT_MAX    = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_SAMPLES = 2'd3;

  // reset values
  localparam logic [SAMPLE_BITS-1:0] RST_CAL_MIN     = '0;
  localparam logic [SAMPLE_BITS-1:0] RST_CAL_CENTER  = SAMPLE_BITS'(2048);
  localparam logic [SAMPLE_BITS-1:0] RST_CAL_MAX     = '1;
  localparam logic [COUNT_BITS-1:0]  RST_MIN_SAMPLES = COUNT_BITS'(5);

  typedef enum logic [PHASE_BITS-1:0] {
    PH_IDLE     = 2'd0,
    PH_EXTREMES = 2'd1,
    PH_CENTER   = 2'd2,
    PH_DONE     = 2'd3
  } phase_t;

  typedef struct packed {
    logic accept;   // take the input word and update state
    logic step;     // one divider iteration
    logic finish;   // commit center, load output word
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } ctrl_sts_t;

endpackage

// ===== src/arcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arcc_ctrl
// Sequencer: accept a word, run the divider, load the result, hand it off.
// ----------------------------------------------------------------------------
module arcc_ctrl import arcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DIV;
      S_DIV:  if (sts.div_last) state_next = S_FIN;
      S_FIN:  state_next = S_OUT;
      S_OUT:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign cmd.accept = (state == S_IDLE) && in_valid;
  assign cmd.step   = (state == S_DIV);
  assign cmd.finish = (state == S_FIN);

endmodule

// ===== src/arcc_dp.sv =====
// ----------------------------------------------------------------------------
// arcc_dp
// Calibration state, restoring divider for the center mean, output word.
// ----------------------------------------------------------------------------
module arcc_dp import arcc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  output ctrl_sts_t                sts,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic [MODE_BITS-1:0]     mode,
  input  logic [SAMPLE_BITS-1:0]   sample,
  output logic [PHASE_BITS-1:0]    phase_now,
  output logic [SAMPLE_BITS-1:0]   live_value,
  output logic [SAMPLE_BITS-1:0]   tracked_min,
  output logic [SAMPLE_BITS-1:0]   tracked_max,
  output logic [SAMPLE_BITS-1:0]   running_center,
  output logic [SAMPLE_BITS-1:0]   result_min,
  output logic [SAMPLE_BITS-1:0]   result_center,
  output logic [SAMPLE_BITS-1:0]   result_max,
  output logic                     command_refused,
  output logic                     apply_allowed
);

  phase_t                 phase, phase_next;
  logic [SAMPLE_BITS-1:0] sweep_min, sweep_min_next;
  logic [SAMPLE_BITS-1:0] sweep_max, sweep_max_next;
  logic [SUM_BITS-1:0]    center_sum, center_sum_next;
  logic [COUNT_BITS-1:0]  center_count, center_count_next;
  logic [SAMPLE_BITS-1:0] cal_min, cal_min_next;
  logic [SAMPLE_BITS-1:0] cal_max, cal_max_next;
  logic [SAMPLE_BITS-1:0] cal_center;
  logic [SAMPLE_BITS-1:0] last_sample;
  logic [COUNT_BITS-1:0]  min_samples;
  logic                   refused, refused_next;
  logic                   commit, commit_next;

  // divider: remainder and dividend/quotient shift register
  logic [COUNT_BITS-1:0]  rem;
  logic [SUM_BITS-1:0]    quo;
  logic [STEP_BITS-1:0]   step_cnt;
  logic [COUNT_BITS:0]    rem_sh;
  logic [COUNT_BITS:0]    rem_diff;
  logic                   q_bit;
  logic [SAMPLE_BITS-1:0] mean;

  always_comb begin
    phase_next        = phase;
    sweep_min_next    = sweep_min;
    sweep_max_next    = sweep_max;
    center_sum_next   = center_sum;
    center_count_next = center_count;
    cal_min_next      = cal_min;
    cal_max_next      = cal_max;
    refused_next      = 1'b0;
    commit_next       = 1'b0;
    case (mode)
      MODE_SAMPLE: begin
        if (phase == PH_EXTREMES) begin
          if (sample < sweep_min) sweep_min_next = sample;
          if (sample > sweep_max) sweep_max_next = sample;
        end else if (phase == PH_CENTER && center_count != '1) begin
          center_sum_next   = center_sum + SUM_BITS'(sample);
          center_count_next = center_count + 1'b1;
        end
      end
      MODE_EXTREMES: begin
        if (phase == PH_EXTREMES) begin
          if (sweep_min < sweep_max) begin
            cal_min_next = sweep_min;
            cal_max_next = sweep_max;
          end
          phase_next        = PH_CENTER;
          center_sum_next   = '0;
          center_count_next = '0;
        end else begin
          sweep_min_next = '1;
          sweep_max_next = '0;
          phase_next     = PH_EXTREMES;
        end
      end
      MODE_CENTER: begin
        if (phase != PH_IDLE) begin
          if (center_count == '0 || center_count < min_samples) begin
            refused_next = 1'b1;
          end else begin
            commit_next = 1'b1;
            phase_next  = PH_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  assign rem_sh   = {rem, quo[SUM_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, center_count};
  assign q_bit    = (rem_sh >= {1'b0, center_count});
  assign mean     = (center_count == '0) ? '0 : quo[SAMPLE_BITS-1:0];
  assign sts.div_last = (step_cnt == STEP_BITS'(SUM_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      sweep_min    <= '1;
      sweep_max    <= '0;
      center_sum   <= '0;
      center_count <= '0;
      cal_min      <= RST_CAL_MIN;
      cal_center   <= RST_CAL_CENTER;
      cal_max      <= RST_CAL_MAX;
      last_sample  <= '0;
      min_samples  <= RST_MIN_SAMPLES;
      refused      <= 1'b0;
      commit       <= 1'b0;
      step_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_INIT_MIN:    cal_min     <= cfg_wdata[SAMPLE_BITS-1:0];
          REG_INIT_CENTER: cal_center  <= cfg_wdata[SAMPLE_BITS-1:0];
          REG_INIT_MAX:    cal_max     <= cfg_wdata[SAMPLE_BITS-1:0];
          REG_MIN_SAMPLES: min_samples <= cfg_wdata[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        phase        <= phase_next;
        sweep_min    <= sweep_min_next;
        sweep_max    <= sweep_max_next;
        center_sum   <= center_sum_next;
        center_count <= center_count_next;
        cal_min      <= cal_min_next;
        cal_max      <= cal_max_next;
        if (mode == MODE_SAMPLE) last_sample <= sample;
        refused      <= refused_next;
        commit       <= commit_next;
        step_cnt     <= '0;
      end else if (cmd.step) begin
        step_cnt <= step_cnt + 1'b1;
      end
      if (cmd.finish && commit) cal_center <= mean;
    end
  end

  // divider datapath and output word, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rem <= '0;
      quo <= center_sum_next;
    end else if (cmd.step) begin
      rem <= q_bit ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      quo <= {quo[SUM_BITS-2:0], q_bit};
    end
    if (cmd.finish) begin
      phase_now       <= PHASE_BITS'(phase);
      live_value      <= last_sample;
      tracked_min     <= sweep_min;
      tracked_max     <= sweep_max;
      running_center  <= mean;
      result_min      <= cal_min;
      result_center   <= commit ? mean : cal_center;
      result_max      <= cal_max;
      command_refused <= refused;
      apply_allowed   <= (phase == PH_CENTER) || (phase == PH_DONE);
    end
  end

endmodule

// ===== src/axis_range_center_calibrator.sv =====
// Flow: accepting an input word starts the bit-serial 28-by-16 divider;
// after its 28 iterations the result is loaded and out_valid rises.
// One word in flight at a time; in_stall is high until the result is taken.
// Reset (rst, synchronous): phase idle, sweep/center state cleared,
// calibration values and sample threshold back to their defaults.
// ----------------------------------------------------------------------------
// axis_range_center_calibrator
// Min/max sweep and center averaging calibration for one axis.
// ----------------------------------------------------------------------------
module axis_range_center_calibrator import arcc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [MODE_BITS-1:0]     mode,
  input  logic [SAMPLE_BITS-1:0]   sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PHASE_BITS-1:0]    phase_now,
  output logic [SAMPLE_BITS-1:0]   live_value,
  output logic [SAMPLE_BITS-1:0]   tracked_min,
  output logic [SAMPLE_BITS-1:0]   tracked_max,
  output logic [SAMPLE_BITS-1:0]   running_center,
  output logic [SAMPLE_BITS-1:0]   result_min,
  output logic [SAMPLE_BITS-1:0]   result_center,
  output logic [SAMPLE_BITS-1:0]   result_max,
  output logic                     command_refused,
  output logic                     apply_allowed
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  arcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  arcc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .mode            (mode),
    .sample          (sample),
    .phase_now       (phase_now),
    .live_value      (live_value),
    .tracked_min     (tracked_min),
    .tracked_max     (tracked_max),
    .running_center  (running_center),
    .result_min      (result_min),
    .result_center   (result_center),
    .result_max      (result_max),
    .command_refused (command_refused),
    .apply_allowed   (apply_allowed)
  );

endmodule

// ===== bench/arcc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arcc_checker
// Watches the calibrator's config port and both word channels, keeps its own
// copy of the calibration state, and compares every output word field by
// field against the prediction for the oldest outstanding input word.
// ----------------------------------------------------------------------------
module arcc_checker import arcc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [MODE_BITS-1:0]     mode,
  input  logic [SAMPLE_BITS-1:0]   sample,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [PHASE_BITS-1:0]    phase_now,
  input  logic [SAMPLE_BITS-1:0]   live_value,
  input  logic [SAMPLE_BITS-1:0]   tracked_min,
  input  logic [SAMPLE_BITS-1:0]   tracked_max,
  input  logic [SAMPLE_BITS-1:0]   running_center,
  input  logic [SAMPLE_BITS-1:0]   result_min,
  input  logic [SAMPLE_BITS-1:0]   result_center,
  input  logic [SAMPLE_BITS-1:0]   result_max,
  input  logic                     command_refused,
  input  logic                     apply_allowed,
  output int                       fail_count,
  output int                       pending,
  output int                       words_in,
  output int                       words_out,
  output int                       centers_taken,
  output int                       refusals
);

  typedef struct packed {
    phase_t                 ph;
    logic [SAMPLE_BITS-1:0] live;
    logic [SAMPLE_BITS-1:0] tmin;
    logic [SAMPLE_BITS-1:0] tmax;
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] rmin;
    logic [SAMPLE_BITS-1:0] rcenter;
    logic [SAMPLE_BITS-1:0] rmax;
    logic                   refused;
    logic                   apply;
  } calib_word_t;

  calib_word_t expected_words[$];

  phase_t                 phase;
  logic [SAMPLE_BITS-1:0] sweep_min, sweep_max, last_sample;
  logic [SAMPLE_BITS-1:0] cal_min, cal_center, cal_max;
  logic [SUM_BITS-1:0]    center_sum;
  logic [COUNT_BITS-1:0]  center_count, min_samples;

  task automatic report(string msg);
    fail_count++;
    $display("ERROR: %s", msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report($sformatf("word %0d %s: got %0d, expected %0d", words_out, name, got, want));
  endtask

  function automatic logic [SAMPLE_BITS-1:0] center_mean();
    if (center_count == '0) return '0;
    return SAMPLE_BITS'(center_sum / center_count);
  endfunction

  // advances the calibration state by one input word, returns the output word
  function automatic calib_word_t calibrate_word(logic [MODE_BITS-1:0] md,
                                                 logic [SAMPLE_BITS-1:0] smp);
    calib_word_t w;
    logic        refused;
    refused = 1'b0;
    case (md)
      MODE_SAMPLE: begin
        last_sample = smp;
        if (phase == PH_EXTREMES) begin
          if (smp < sweep_min) sweep_min = smp;
          if (smp > sweep_max) sweep_max = smp;
        end else if (phase == PH_CENTER && center_count != '1) begin
          center_sum   = center_sum + SUM_BITS'(smp);
          center_count = center_count + 1'b1;
        end
      end
      MODE_EXTREMES: begin
        if (phase == PH_EXTREMES) begin
          // a degenerate sweep keeps the old range
          if (sweep_min < sweep_max) begin
            cal_min = sweep_min;
            cal_max = sweep_max;
          end
          phase        = PH_CENTER;
          center_sum   = '0;
          center_count = '0;
        end else begin
          sweep_min = '1;
          sweep_max = '0;
          phase     = PH_EXTREMES;
        end
      end
      MODE_CENTER: begin
        if (phase != PH_IDLE) begin
          if (center_count == '0 || center_count < min_samples) begin
            refused = 1'b1;
            refusals++;
          end else begin
            cal_center = center_mean();
            phase      = PH_DONE;
            centers_taken++;
          end
        end
      end
      default: ;
    endcase
    w.ph      = phase;
    w.live    = last_sample;
    w.tmin    = sweep_min;
    w.tmax    = sweep_max;
    w.mean    = center_mean();
    w.rmin    = cal_min;
    w.rcenter = cal_center;
    w.rmax    = cal_max;
    w.refused = refused;
    w.apply   = (phase == PH_CENTER || phase == PH_DONE);
    return w;
  endfunction

  always @(posedge clk) begin
    calib_word_t want;
    if (rst) begin
      phase        = PH_IDLE;
      sweep_min    = '1;
      sweep_max    = '0;
      last_sample  = '0;
      center_sum   = '0;
      center_count = '0;
      cal_min      = RST_CAL_MIN;
      cal_center   = RST_CAL_CENTER;
      cal_max      = RST_CAL_MAX;
      min_samples  = RST_MIN_SAMPLES;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report($sformatf("output word %0d with no input word outstanding", words_out));
        end else begin
          want = expected_words.pop_front();
          check_field("phase_now", phase_now, want.ph);
          check_field("live_value", live_value, want.live);
          check_field("tracked_min", tracked_min, want.tmin);
          check_field("tracked_max", tracked_max, want.tmax);
          check_field("running_center", running_center, want.mean);
          check_field("result_min", result_min, want.rmin);
          check_field("result_center", result_center, want.rcenter);
          check_field("result_max", result_max, want.rmax);
          check_field("command_refused", command_refused, want.refused);
          check_field("apply_allowed", apply_allowed, want.apply);
        end
        words_out++;
      end
      if (cfg_we) begin
        // writing an initial value also loads the committed value
        case (cfg_addr)
          REG_INIT_MIN:    cal_min     = cfg_wdata[SAMPLE_BITS-1:0];
          REG_INIT_CENTER: cal_center  = cfg_wdata[SAMPLE_BITS-1:0];
          REG_INIT_MAX:    cal_max     = cfg_wdata[SAMPLE_BITS-1:0];
          REG_MIN_SAMPLES: min_samples = cfg_wdata[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_words.push_back(calibrate_word(mode, sample));
        words_in++;
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== bench/axis_range_center_calibrator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_range_center_calibrator_test
// Drives directed and random calibration sequences into the calibrator under
// several register settings and idle patterns; arcc_checker does the checking.
// ----------------------------------------------------------------------------
module axis_range_center_calibrator_test;
  import arcc_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_RESERVED = 2'd3;
  localparam int PHASE_WORDS  = 316;
  localparam int HOLD_MARK    = 900;
  localparam int HOLD_CYCLES  = 400;
  localparam int END_LIMIT    = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [MODE_BITS-1:0]     mode;
  logic [SAMPLE_BITS-1:0]   sample;
  logic                     out_valid;
  logic                     out_stall;
  logic [PHASE_BITS-1:0]    phase_now;
  logic [SAMPLE_BITS-1:0]   live_value;
  logic [SAMPLE_BITS-1:0]   tracked_min;
  logic [SAMPLE_BITS-1:0]   tracked_max;
  logic [SAMPLE_BITS-1:0]   running_center;
  logic [SAMPLE_BITS-1:0]   result_min;
  logic [SAMPLE_BITS-1:0]   result_center;
  logic [SAMPLE_BITS-1:0]   result_max;
  logic                     command_refused;
  logic                     apply_allowed;

  int fail_count, pending, words_in, words_out, centers_taken, refusals;
  int send_gap_pct, recv_stall_pct;
  int thr;
  int settings_used;
  int hold_left;
  bit hold_done;

  axis_range_center_calibrator i_dut (.*);

  arcc_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("timeout: %0d words accepted, %0d results outstanding", words_in, pending);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver; one long hold-off lets the block fill and stall its input
  always @(negedge clk) begin
    if (!hold_done && words_in >= HOLD_MARK) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_word(logic [MODE_BITS-1:0] md, logic [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= md;
    sample   <= smp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // only called with the block idle
  task automatic write_settings(int unsigned init_min, int unsigned init_center,
                                int unsigned init_max, int unsigned min_samples);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_INIT_MIN;
    cfg_wdata <= CFG_DATA_BITS'(init_min);
    @(negedge clk);
    cfg_addr  <= REG_INIT_CENTER;
    cfg_wdata <= CFG_DATA_BITS'(init_center);
    @(negedge clk);
    cfg_addr  <= REG_INIT_MAX;
    cfg_wdata <= CFG_DATA_BITS'(init_max);
    @(negedge clk);
    cfg_addr  <= REG_MIN_SAMPLES;
    cfg_wdata <= CFG_DATA_BITS'(min_samples);
    @(negedge clk);
    cfg_we    <= 1'b0;
    thr = min_samples;
    settings_used++;
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int phase_end, n, lo, hi, c, spread, v;
    bit flat;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_addr       = REG_INIT_MIN;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    mode           = MODE_SAMPLE;
    sample         = '0;
    out_stall      = 1'b0;
    send_gap_pct   = 8;
    recv_stall_pct = 48;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed walk through the phases and the odd corners
    write_settings(0, 4095, 4095, 3);
    send_word(MODE_RESERVED, 12'hFFF);   // reserved mode is a no-op
    send_word(MODE_SAMPLE, 12'hFFF);     // sample while idle
    send_word(MODE_CENTER, 12'h000);     // center while idle: ignored
    send_word(MODE_EXTREMES, 12'h000);
    send_word(MODE_CENTER, 12'h000);     // nothing counted yet: refused
    send_word(MODE_EXTREMES, 12'h000);   // empty sweep keeps old range
    send_word(MODE_SAMPLE, 12'hFFF);
    send_word(MODE_CENTER, 12'h000);     // below threshold
    send_word(MODE_SAMPLE, 12'h000);
    send_word(MODE_SAMPLE, 12'd2730);
    send_word(MODE_CENTER, 12'h000);     // commits
    send_word(MODE_SAMPLE, 12'd100);     // done: only live value moves
    send_word(MODE_CENTER, 12'h000);     // commits again from done
    send_word(MODE_RESERVED, 12'h000);
    send_word(MODE_EXTREMES, 12'h000);   // restart sweep from done
    send_word(MODE_SAMPLE, 12'h000);
    send_word(MODE_SAMPLE, 12'hFFF);
    send_word(MODE_SAMPLE, 12'd2048);
    send_word(MODE_CENTER, 12'h000);     // center in sweep uses leftover sum
    send_word(MODE_EXTREMES, 12'h000);
    send_word(MODE_SAMPLE, 12'd5);
    send_word(MODE_SAMPLE, 12'd4000);
    send_word(MODE_EXTREMES, 12'h000);   // good sweep commits
    send_word(MODE_SAMPLE, 12'd1234);
    send_word(MODE_EXTREMES, 12'h000);   // from center: restart sweep
    finish_phase();

    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_gap_pct   = 8;
        recv_stall_pct = 48;
      end else if (p < 4) begin
        send_gap_pct   = 48;
        recv_stall_pct = 8;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      case (p)
        0: write_settings(0, 2048, 4095, 5);
        1: write_settings(4095, 0, 0, 1);
        2: write_settings($urandom_range(4095), $urandom_range(4095),
                          $urandom_range(4095), $urandom_range(2, 12));
        3: write_settings(0, 0, 4095, 65535);
        4: write_settings(4095, 4095, 4095, 16);
        default: write_settings($urandom_range(4095), $urandom_range(4095),
                                $urandom_range(4095), $urandom_range(1, 20));
      endcase
      phase_end = words_in + PHASE_WORDS;
      while (words_in < phase_end) begin
        if ($urandom_range(99) < 20) begin
          // stray words in whatever phase the block is in
          repeat ($urandom_range(1, 4))
            send_word(MODE_BITS'($urandom_range(3)), SAMPLE_BITS'($urandom_range(4095)));
        end else begin
          send_word(MODE_EXTREMES, SAMPLE_BITS'($urandom_range(4095)));
          n    = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 12);
          lo   = $urandom_range(4095);
          hi   = $urandom_range(4095, lo);
          flat = ($urandom_range(9) == 0);
          c    = $urandom_range(hi, lo);
          repeat (n)
            send_word(MODE_SAMPLE, SAMPLE_BITS'(flat ? c : $urandom_range(hi, lo)));
          // now and then the sweep is abandoned
          if ($urandom_range(9) != 0) begin
            send_word(MODE_EXTREMES, SAMPLE_BITS'($urandom_range(4095)));
            spread = $urandom_range(64);
            c      = $urandom_range(4095);
            n      = $urandom_range(((thr < 20) ? thr : 20) + 3);
            repeat (n) begin
              v = c - spread + int'($urandom_range(2 * spread));
              if (v < 0) v = 0;
              else if (v > 4095) v = 4095;
              send_word(MODE_SAMPLE, SAMPLE_BITS'(v));
            end
            send_word(MODE_CENTER, SAMPLE_BITS'($urandom_range(4095)));
            if ($urandom_range(1) == 1) begin
              repeat ($urandom_range(6))
                send_word(MODE_SAMPLE, SAMPLE_BITS'($urandom_range(4095)));
              send_word(MODE_CENTER, SAMPLE_BITS'($urandom_range(4095)));
            end
          end
        end
      end
      finish_phase();
    end

    for (int i = 0; i < END_LIMIT && pending != 0; i++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending != 0) $display("ERROR: %0d expected words never came out", pending);
    $display("Ran %0d words through %0d register settings, %0d outputs compared.",
             words_in, settings_used, words_out);
    $display("Center captures committed: %0d, center commands refused: %0d.",
             centers_taken, refusals);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
